### sv/rplg_pkg.sv
// ============================================================================
// rplg_pkg: shared types and constants of the RLE palette loader
// Palette geometry, header length, decoder codes and store write port.
// ============================================================================
package rplg_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int HEADER_BYTES    = 18;

   localparam int ROW_W      = $clog2(PALETTE_ENTRIES);
   localparam int ROW_CNT_W  = ROW_W + 1;
   localparam int COMP_W     = 6;
   localparam int ROW_DATA_W = 3 * COMP_W;
   localparam int HDR_W      = 5;

   localparam logic [7:0] ESCAPE_CODE = 8'hFF;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [1:0] {
      PH_LITERAL,
      PH_VALUE,
      PH_COUNT
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_PAD,
      ST_READ,
      ST_CORR
   } state_type;

   typedef struct packed {
      logic                  en;
      logic [ROW_W-1:0]      row;
      logic [ROW_DATA_W-1:0] data;
   } wr_type;

endpackage

### sv/rplg_store.sv
// ============================================================================
// rplg_store: palette row memory
// One RGB triplet per row, per-row valid bits cleared by reset, registered
// read that returns zero for a row never written since reset.
// ============================================================================
module rplg_store (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rplg_pkg::wr_type                       wr,
   input  logic [rplg_pkg::ROW_W-1:0]             rd_addr,
   output logic [rplg_pkg::ROW_DATA_W-1:0]        rd_data
);

   logic [rplg_pkg::ROW_DATA_W-1:0] mem [rplg_pkg::PALETTE_ENTRIES];
   logic [rplg_pkg::PALETTE_ENTRIES-1:0] valid_ff;
   logic [rplg_pkg::ROW_DATA_W-1:0] rd_data_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.row] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.row] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### sv/rplg_gamma.sv
// ============================================================================
// rplg_gamma: gamma correction of one 6-bit component
// min(63, (g*(64-c)+32)>>6) for nonzero g and c, then 6-to-8 bit expansion.
// ============================================================================
module rplg_gamma (
   input  logic [7:0]                   gamma_level,
   input  logic [rplg_pkg::COMP_W-1:0]  comp,
   output logic [7:0]                   comp_out
);

   logic [6:0]  inv_comp;
   logic [14:0] product;
   logic [15:0] rounded;
   logic [9:0]  scaled;
   logic [5:0]  corrected;

   always_comb begin
      inv_comp  = 7'd64 - {1'b0, comp};
      product   = 15'(gamma_level * inv_comp);
      rounded   = {1'b0, product} + 16'd32;
      scaled    = rounded[15:6];
      if (gamma_level == 8'd0 || comp == 6'd0) begin
         corrected = comp;
      end else if (scaled > 10'd63) begin
         corrected = 6'd63;
      end else begin
         corrected = scaled[5:0];
      end
      comp_out = {corrected, corrected[5:4]};
   end

endmodule

### sv/rle_palette_loader_gamma.sv
// ============================================================================
// rle_palette_loader_gamma: RLE palette loader with gamma-corrected readout
// Skips the stream header, expands escape runs into RGB triplets, pads short
// streams with zeros and reads entries back through a gamma curve.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------
//   request  | req_command .. req_entry_index          | start & !busy
//   response | rsp_red_out, rsp_green_out, rsp_blue_out| rsp_strobe, 1 cycle
//   csr      | csr_gamma_level                         | csr_valid & ready
//
// A plain or header byte passes through ST_LOAD alone; a run then stays in ST_RUN,
// placing each component through the single sequencer datapath, one store write per triplet.
// Stream end pads the remaining triplets at one component per cycle.
// A read goes through ST_READ (memory read), then ST_CORR: one shared gamma unit for R, G, B in turn.
// Reset clears the row valid bits at once; no clearing pass is needed.
// The receiver cannot stall: rsp_strobe marks the single result cycle.
// ============================================================================
module rle_palette_loader_gamma (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       req_skip_black,
   input  logic [7:0] req_entry_index,
   output logic       rsp_strobe,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_gamma_level
);

   localparam logic [rplg_pkg::ROW_CNT_W-1:0] ENTRIES_CNT =
      rplg_pkg::ROW_CNT_W'(rplg_pkg::PALETTE_ENTRIES);
   localparam logic [rplg_pkg::HDR_W:0] HDR_LEN =
      (rplg_pkg::HDR_W + 1)'(rplg_pkg::HEADER_BYTES);

   rplg_pkg::state_type state_ff, state_in;
   rplg_pkg::phase_type phase_ff, phase_in;

   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       skip_ff, skip_in;
   logic [7:0] index_ff, index_in;

   logic [rplg_pkg::HDR_W-1:0]     hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]                     run_value_ff, run_value_in;
   logic [7:0]                     run_left_ff, run_left_in;
   logic [7:0]                     held0_ff, held0_in;
   logic [7:0]                     held1_ff, held1_in;
   logic [1:0]                     comp_pos_ff, comp_pos_in;
   logic [rplg_pkg::ROW_CNT_W-1:0] row_ff, row_in;
   logic [1:0]                     sel_ff, sel_in;
   logic [7:0]                     red_ff, red_in;
   logic [7:0]                     green_ff, green_in;
   logic [7:0]                     blue_ff, blue_in;
   logic                           strobe_ff, strobe_in;
   logic [7:0]                     gamma_ff, gamma_in;

   logic                           accept;
   logic                           hdr_active;
   logic [rplg_pkg::HDR_W:0]       hdr_next;
   logic                           hdr_done;
   logic                           full;
   logic                           in_range;
   logic                           place_en;
   logic [7:0]                     place_val;
   logic                           restart;
   rplg_pkg::wr_type               wr;
   logic [rplg_pkg::ROW_DATA_W-1:0] rd_data;
   logic [rplg_pkg::COMP_W-1:0]    corr_comp;
   logic [7:0]                     corr_out;

   rplg_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (index_ff[rplg_pkg::ROW_W-1:0]),
      .rd_data (rd_data)
   );

   rplg_gamma u_gamma (
      .gamma_level (gamma_ff),
      .comp        (corr_comp),
      .comp_out    (corr_out)
   );

   assign accept     = start && !busy;
   assign busy       = (state_ff != rplg_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign hdr_active = ({1'b0, hdr_cnt_ff} < HDR_LEN);
   assign hdr_next   = {1'b0, hdr_cnt_ff} + 1'b1;
   assign hdr_done   = (hdr_next >= HDR_LEN);
   assign full       = (row_ff >= ENTRIES_CNT);
   assign in_range   = ({1'b0, index_ff} < 9'(rplg_pkg::PALETTE_ENTRIES));

   assign rsp_strobe    = strobe_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

   always_comb begin
      unique case (sel_ff)
         2'd0:    corr_comp = in_range ? rd_data[17:12] : '0;
         2'd1:    corr_comp = in_range ? rd_data[11:6] : '0;
         2'd2:    corr_comp = in_range ? rd_data[5:0] : '0;
         default: corr_comp = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rplg_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_command == rplg_pkg::CMD_READ) ?
                          rplg_pkg::ST_READ : rplg_pkg::ST_LOAD;
            end
         end
         rplg_pkg::ST_LOAD: begin
            if (hdr_active) begin
               state_in = (last_ff && hdr_done) ? rplg_pkg::ST_PAD : rplg_pkg::ST_IDLE;
            end else if (!full && phase_ff == rplg_pkg::PH_COUNT) begin
               state_in = rplg_pkg::ST_RUN;
            end else begin
               state_in = last_ff ? rplg_pkg::ST_PAD : rplg_pkg::ST_IDLE;
            end
         end
         rplg_pkg::ST_RUN: begin
            if (run_left_ff == 8'd0 || full) begin
               state_in = last_ff ? rplg_pkg::ST_PAD : rplg_pkg::ST_IDLE;
            end
         end
         rplg_pkg::ST_PAD: begin
            if (full) begin
               state_in = rplg_pkg::ST_IDLE;
            end
         end
         rplg_pkg::ST_READ: state_in = rplg_pkg::ST_CORR;
         rplg_pkg::ST_CORR: begin
            if (sel_ff == 2'd2) begin
               state_in = rplg_pkg::ST_IDLE;
            end
         end
         default: state_in = rplg_pkg::ST_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      byte_in      = byte_ff;
      last_in      = last_ff;
      skip_in      = skip_ff;
      index_in     = index_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      phase_in     = phase_ff;
      run_value_in = run_value_ff;
      run_left_in  = run_left_ff;
      held0_in     = held0_ff;
      held1_in     = held1_ff;
      comp_pos_in  = comp_pos_ff;
      row_in       = row_ff;
      sel_in       = sel_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      strobe_in    = 1'b0;
      gamma_in     = (csr_valid && csr_ready) ? csr_gamma_level : gamma_ff;
      place_en     = 1'b0;
      place_val    = 8'd0;
      restart      = 1'b0;
      wr.en        = 1'b0;
      wr.row       = row_ff[rplg_pkg::ROW_W-1:0];
      wr.data      = '0;

      unique case (state_ff)
         rplg_pkg::ST_IDLE: begin
            if (accept) begin
               byte_in  = req_data_byte;
               last_in  = req_last_byte;
               skip_in  = req_skip_black;
               index_in = req_entry_index;
            end
         end
         rplg_pkg::ST_LOAD: begin
            if (hdr_active) begin
               hdr_cnt_in = hdr_next[rplg_pkg::HDR_W-1:0];
               restart    = last_ff && !hdr_done;
            end else if (!full) begin
               unique case (phase_ff)
                  rplg_pkg::PH_VALUE: begin
                     run_value_in = byte_ff;
                     phase_in     = rplg_pkg::PH_COUNT;
                  end
                  rplg_pkg::PH_COUNT: begin
                     run_left_in = byte_ff;
                     phase_in    = rplg_pkg::PH_LITERAL;
                  end
                  rplg_pkg::PH_LITERAL: begin
                     if (byte_ff == rplg_pkg::ESCAPE_CODE) begin
                        phase_in = rplg_pkg::PH_VALUE;
                     end else begin
                        place_en  = 1'b1;
                        place_val = byte_ff;
                     end
                  end
                  default: phase_in = rplg_pkg::PH_LITERAL;
               endcase
            end
         end
         rplg_pkg::ST_RUN: begin
            if (run_left_ff != 8'd0 && !full) begin
               place_en    = 1'b1;
               place_val   = run_value_ff;
               run_left_in = run_left_ff - 8'd1;
            end
         end
         rplg_pkg::ST_PAD: begin
            if (full) begin
               restart = 1'b1;
            end else begin
               place_en = 1'b1;
            end
         end
         rplg_pkg::ST_READ: sel_in = 2'd0;
         rplg_pkg::ST_CORR: begin
            unique case (sel_ff)
               2'd0:    red_in   = corr_out;
               2'd1:    green_in = corr_out;
               default: blue_in  = corr_out;
            endcase
            sel_in    = sel_ff + 2'd1;
            strobe_in = (sel_ff == 2'd2);
         end
         default: ;
      endcase

      // place one component; the third completes a triplet
      if (place_en) begin
         priority case (comp_pos_ff)
            2'd0: begin
               held0_in    = place_val;
               comp_pos_in = 2'd1;
            end
            2'd1: begin
               held1_in    = place_val;
               comp_pos_in = 2'd2;
            end
            default: begin
               wr.en       = !(skip_ff && held0_ff == 8'd0 && held1_ff == 8'd0
                               && place_val == 8'd0);
               wr.data     = {held0_ff[5:0], held1_ff[5:0], place_val[5:0]};
               comp_pos_in = 2'd0;
               row_in      = row_ff + 1'b1;
            end
         endcase
      end

      if (restart) begin
         hdr_cnt_in   = '0;
         phase_in     = rplg_pkg::PH_LITERAL;
         run_value_in = 8'd0;
         held0_in     = 8'd0;
         held1_in     = 8'd0;
         comp_pos_in  = 2'd0;
         row_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rplg_pkg::ST_IDLE;
         phase_ff     <= rplg_pkg::PH_LITERAL;
         hdr_cnt_ff   <= '0;
         run_value_ff <= 8'd0;
         run_left_ff  <= 8'd0;
         held0_ff     <= 8'd0;
         held1_ff     <= 8'd0;
         comp_pos_ff  <= 2'd0;
         row_ff       <= '0;
         sel_ff       <= 2'd0;
         strobe_ff    <= 1'b0;
         gamma_ff     <= 8'd0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         run_value_ff <= run_value_in;
         run_left_ff  <= run_left_in;
         held0_ff     <= held0_in;
         held1_ff     <= held1_in;
         comp_pos_ff  <= comp_pos_in;
         row_ff       <= row_in;
         sel_ff       <= sel_in;
         strobe_ff    <= strobe_in;
         gamma_ff     <= gamma_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      skip_ff  <= skip_in;
      index_ff <= index_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

endmodule
